[hw/rtl/rpp_pkg.sv]
// Package with the shared types, widths and register indexes of the point rotate/project core.
package rpp_pkg;

  // Coordinate format: signed, 16 fraction bits.
  localparam int COORD_WIDTH    = 32;
  // Coefficient format: signed, COEF_FRAC_BITS fraction bits.
  localparam int COEF_FRAC_BITS = 14;
  localparam int TRIG_WIDTH     = 16;
  localparam int SCALE_WIDTH    = 18;
  localparam int COEF_WIDTH     = SCALE_WIDTH;
  localparam int CFG_IDX_WIDTH  = 3;
  localparam int CFG_DATA_WIDTH = SCALE_WIDTH;

  // Datapath widths inside one multiply-accumulate unit.
  localparam int PROD_WIDTH = COORD_WIDTH + COEF_WIDTH;
  localparam int SUM_WIDTH  = PROD_WIDTH + 1;

  // Number of register stages from input transfer to output register.
  localparam int NUM_STAGES = 8;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [COEF_WIDTH-1:0]  coef_t;
  typedef logic signed [TRIG_WIDTH-1:0]  trig_t;
  typedef logic signed [SCALE_WIDTH-1:0] scale_t;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_WIDTH-1:0] REG_COS_X   = 3'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_SIN_X   = 3'd1;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_COS_Y   = 3'd2;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_SIN_Y   = 3'd3;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_COS_Z   = 3'd4;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_SIN_Z   = 3'd5;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_SCALE_X = 3'd6;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_SCALE_Y = 3'd7;

  // Register reset values.
  localparam trig_t  TRIG_ONE  = trig_t'(1 << COEF_FRAC_BITS);
  localparam trig_t  TRIG_ZERO = '0;
  localparam scale_t SCALE_ONE = scale_t'(1 << COEF_FRAC_BITS);

  // Load enables for the two register stages of one multiply-accumulate unit.
  typedef struct packed {
    logic mul;
    logic sum;
  } stage_en_t;

endpackage

[hw/rtl/rpp_mac2.sv]
// Two-stage multiply-accumulate unit: round(a1*b1 +/- a2*b2) with Q16.16 saturation.
module rpp_mac2 (
  input  logic               clk_i,
  input  rpp_pkg::stage_en_t en_i,
  input  rpp_pkg::coord_t    a1_i,
  input  rpp_pkg::coef_t     b1_i,
  input  rpp_pkg::coord_t    a2_i,
  input  rpp_pkg::coef_t     b2_i,
  input  logic               sub_i,
  output rpp_pkg::coord_t    r_o,
  output logic               sat_o
);

  localparam int SumW  = rpp_pkg::SUM_WIDTH;
  localparam int CrdW  = rpp_pkg::COORD_WIDTH;
  localparam int FracW = rpp_pkg::COEF_FRAC_BITS;
  localparam logic signed [SumW-1:0] RoundHalf = SumW'(1) <<< (FracW - 1);

  logic signed [rpp_pkg::PROD_WIDTH-1:0] p1_d, p2_d, p1_q, p2_q;
  logic signed [SumW-1:0] sum, rnd;
  logic [SumW-CrdW:0]     rnd_hi;
  logic                   fits;
  rpp_pkg::coord_t        r_d, r_q;
  logic                   sat_d, sat_q;

  // The two products of the first stage.
  assign p1_d = a1_i * b1_i;
  assign p2_d = a2_i * b2_i;

  always_ff @(posedge clk_i) begin
    if (en_i.mul) begin
      p1_q <= p1_d;
      p2_q <= p2_d;
    end
  end

  // Exact sum, round to nearest with ties upward, then clamp to the coordinate range.
  always_comb begin
    if (sub_i) begin
      sum = SumW'(p1_q) - SumW'(p2_q) + RoundHalf;
    end else begin
      sum = SumW'(p1_q) + SumW'(p2_q) + RoundHalf;
    end
    rnd    = sum >>> FracW;
    rnd_hi = rnd[SumW-1:CrdW-1];
    fits   = (&rnd_hi) | ~(|rnd_hi);
    sat_d  = ~fits;
    if (fits) begin
      r_d = rnd[CrdW-1:0];
    end else if (rnd[SumW-1]) begin
      r_d = {1'b1, {(CrdW-1){1'b0}}};
    end else begin
      r_d = {1'b0, {(CrdW-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.sum) begin
      r_q   <= r_d;
      sat_q <= sat_d;
    end
  end

  assign r_o   = r_q;
  assign sat_o = sat_q;

endmodule

[hw/rtl/rotate_project_point_3d_core.sv]
// Top level of the point rotate (Y, X, Z) and orthographic projection pipeline.
//
// Channel | Direction | Handshake                | Payload
// in      | input     | in_valid_i / in_ready_o  | point_x_i, point_y_i, point_z_i
// out     | output    | out_valid_o / out_ready_i| proj_x_o, proj_y_o, saturated_o
// cfg     | input     | cfg_we_i (no wait)       | cfg_idx_i, cfg_data_i
//
// An input transfer reaches the output register through four rotation/projection steps,
// each a multiply stage followed by an add, round and saturate stage.
// One point is taken every cycle while the output side keeps up.
// Each stage holds its item when the stage after it is full and stalled; an empty
// stage anywhere still takes data, so ready goes low only when all stages are full.
// Reset clears the valid bits and loads the identity rotation with unit scales.
module rotate_project_point_3d_core (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [rpp_pkg::CFG_IDX_WIDTH-1:0]    cfg_idx_i,
  input  logic [rpp_pkg::CFG_DATA_WIDTH-1:0]   cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [rpp_pkg::COORD_WIDTH-1:0] point_x_i,
  input  logic signed [rpp_pkg::COORD_WIDTH-1:0] point_y_i,
  input  logic signed [rpp_pkg::COORD_WIDTH-1:0] point_z_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [rpp_pkg::COORD_WIDTH-1:0] proj_x_o,
  output logic signed [rpp_pkg::COORD_WIDTH-1:0] proj_y_o,
  output logic                                 saturated_o
);

  localparam int NSt = rpp_pkg::NUM_STAGES;

  rpp_pkg::trig_t  cos_x_q, sin_x_q, cos_y_q, sin_y_q, cos_z_q, sin_z_q;
  rpp_pkg::scale_t scale_x_q, scale_y_q;

  logic [NSt-1:0] v_q, v_d, en;

  rpp_pkg::coord_t y_q0, y_q1, x1_q2, x1_q3;
  logic [NSt-1:2]  sat_q;

  rpp_pkg::coord_t x1, z1, y2, z2, x3, y3, px, py;
  logic            sat_x1, sat_z1, sat_y2, sat_z2, sat_x3, sat_y3, sat_px, sat_py;

  rpp_pkg::stage_en_t en_y, en_x, en_z, en_p;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cos_x_q   <= rpp_pkg::TRIG_ONE;
      sin_x_q   <= rpp_pkg::TRIG_ZERO;
      cos_y_q   <= rpp_pkg::TRIG_ONE;
      sin_y_q   <= rpp_pkg::TRIG_ZERO;
      cos_z_q   <= rpp_pkg::TRIG_ONE;
      sin_z_q   <= rpp_pkg::TRIG_ZERO;
      scale_x_q <= rpp_pkg::SCALE_ONE;
      scale_y_q <= rpp_pkg::SCALE_ONE;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        rpp_pkg::REG_COS_X:   cos_x_q   <= cfg_data_i[rpp_pkg::TRIG_WIDTH-1:0];
        rpp_pkg::REG_SIN_X:   sin_x_q   <= cfg_data_i[rpp_pkg::TRIG_WIDTH-1:0];
        rpp_pkg::REG_COS_Y:   cos_y_q   <= cfg_data_i[rpp_pkg::TRIG_WIDTH-1:0];
        rpp_pkg::REG_SIN_Y:   sin_y_q   <= cfg_data_i[rpp_pkg::TRIG_WIDTH-1:0];
        rpp_pkg::REG_COS_Z:   cos_z_q   <= cfg_data_i[rpp_pkg::TRIG_WIDTH-1:0];
        rpp_pkg::REG_SIN_Z:   sin_z_q   <= cfg_data_i[rpp_pkg::TRIG_WIDTH-1:0];
        rpp_pkg::REG_SCALE_X: scale_x_q <= cfg_data_i;
        rpp_pkg::REG_SCALE_Y: scale_y_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // Stage enables: a stage loads when it is empty or its content moves on.
  always_comb begin
    en[NSt-1] = ~v_q[NSt-1] | out_ready_i;
    for (int k = NSt - 2; k >= 0; k--) begin
      en[k] = ~v_q[k] | en[k+1];
    end
    v_d[0] = en[0] ? in_valid_i : v_q[0];
    for (int k = 1; k < NSt; k++) begin
      v_d[k] = en[k] ? v_q[k-1] : v_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  assign in_ready_o = en[0];

  assign en_y = '{mul: en[0], sum: en[1]};
  assign en_x = '{mul: en[2], sum: en[3]};
  assign en_z = '{mul: en[4], sum: en[5]};
  assign en_p = '{mul: en[6], sum: en[7]};

  // Rotation about Y.
  rpp_mac2 u_mac_x1 (
    .clk_i, .en_i(en_y),
    .a1_i(point_x_i), .b1_i(rpp_pkg::coef_t'(cos_y_q)),
    .a2_i(point_z_i), .b2_i(rpp_pkg::coef_t'(sin_y_q)),
    .sub_i(1'b0), .r_o(x1), .sat_o(sat_x1)
  );

  rpp_mac2 u_mac_z1 (
    .clk_i, .en_i(en_y),
    .a1_i(point_z_i), .b1_i(rpp_pkg::coef_t'(cos_y_q)),
    .a2_i(point_x_i), .b2_i(rpp_pkg::coef_t'(sin_y_q)),
    .sub_i(1'b1), .r_o(z1), .sat_o(sat_z1)
  );

  // Rotation about X.
  rpp_mac2 u_mac_y2 (
    .clk_i, .en_i(en_x),
    .a1_i(y_q1), .b1_i(rpp_pkg::coef_t'(cos_x_q)),
    .a2_i(z1),   .b2_i(rpp_pkg::coef_t'(sin_x_q)),
    .sub_i(1'b1), .r_o(y2), .sat_o(sat_y2)
  );

  rpp_mac2 u_mac_z2 (
    .clk_i, .en_i(en_x),
    .a1_i(y_q1), .b1_i(rpp_pkg::coef_t'(sin_x_q)),
    .a2_i(z1),   .b2_i(rpp_pkg::coef_t'(cos_x_q)),
    .sub_i(1'b0), .r_o(z2), .sat_o(sat_z2)
  );

  // Rotation about Z.
  rpp_mac2 u_mac_x3 (
    .clk_i, .en_i(en_z),
    .a1_i(x1_q3), .b1_i(rpp_pkg::coef_t'(cos_z_q)),
    .a2_i(y2),    .b2_i(rpp_pkg::coef_t'(sin_z_q)),
    .sub_i(1'b1), .r_o(x3), .sat_o(sat_x3)
  );

  rpp_mac2 u_mac_y3 (
    .clk_i, .en_i(en_z),
    .a1_i(x1_q3), .b1_i(rpp_pkg::coef_t'(sin_z_q)),
    .a2_i(y2),    .b2_i(rpp_pkg::coef_t'(cos_z_q)),
    .sub_i(1'b0), .r_o(y3), .sat_o(sat_y3)
  );

  // Projection scales; the second term is unused.
  rpp_mac2 u_mac_px (
    .clk_i, .en_i(en_p),
    .a1_i(x3), .b1_i(scale_x_q),
    .a2_i('0), .b2_i('0),
    .sub_i(1'b0), .r_o(px), .sat_o(sat_px)
  );

  rpp_mac2 u_mac_py (
    .clk_i, .en_i(en_p),
    .a1_i(y3), .b1_i(scale_y_q),
    .a2_i('0), .b2_i('0),
    .sub_i(1'b0), .r_o(py), .sat_o(sat_py)
  );

  // Delay lines for operands that skip a step, and the running saturation flag.
  always_ff @(posedge clk_i) begin
    if (en[0]) y_q0 <= point_y_i;
    if (en[1]) y_q1 <= y_q0;
    if (en[2]) begin
      x1_q2    <= x1;
      sat_q[2] <= sat_x1 | sat_z1;
    end
    if (en[3]) begin
      x1_q3    <= x1_q2;
      sat_q[3] <= sat_q[2];
    end
    if (en[4]) sat_q[4] <= sat_q[3] | sat_y2 | sat_z2;
    if (en[5]) sat_q[5] <= sat_q[4];
    if (en[6]) sat_q[6] <= sat_q[5] | sat_x3 | sat_y3;
    if (en[7]) sat_q[7] <= sat_q[6];
  end

  assign out_valid_o = v_q[NSt-1];
  assign proj_x_o    = px;
  assign proj_y_o    = py;
  assign saturated_o = sat_q[7] | sat_px | sat_py;

`ifndef SYNTHESIS
  // Any empty stage lets a new transfer in.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(&v_q) |-> in_ready_o)
    else $error("input stalled while the pipeline has a free stage");

  // A ready output side never blocks the input side.
  assert property (@(posedge clk_i) disable iff (!rst_ni) out_ready_i |-> in_ready_o)
    else $error("input stalled while output is ready");

  // An accepted transfer occupies the first stage in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> v_q[0])
    else $error("accepted item missing from first stage");

  // A held first stage keeps its item.
  assert property (@(posedge clk_i) disable iff (!rst_ni) (v_q[0] && !en[0]) |=> v_q[0])
    else $error("stalled item lost from first stage");
`endif

endmodule

[test/tb_rotate_project_point_3d_core.sv]
// Self-checking testbench for the point rotate (Y, X, Z) and projection core.
`timescale 1ns / 100ps

module tb_rotate_project_point_3d_core;

  localparam int     NUM_REGS    = 8;
  localparam int     CYCLE_LIMIT = 200000;
  localparam int     PHASE_ITEMS = 100;
  localparam int     NUM_PHASES  = 7;
  localparam longint COORD_MAX   = (longint'(1) <<< (rpp_pkg::COORD_WIDTH - 1)) - 1;
  localparam longint COORD_MIN   = -(longint'(1) <<< (rpp_pkg::COORD_WIDTH - 1));
  localparam rpp_pkg::coord_t C_MAX = rpp_pkg::coord_t'(COORD_MAX);
  localparam rpp_pkg::coord_t C_MIN = rpp_pkg::coord_t'(COORD_MIN);

  // One projected point as the core should present it.
  typedef struct packed {
    rpp_pkg::coord_t px;
    rpp_pkg::coord_t py;
    logic            sat;
  } proj_t;

  logic                               clk_i       = 1'b0;
  logic                               rst_ni      = 1'b0;
  logic                               cfg_we_i    = 1'b0;
  logic [rpp_pkg::CFG_IDX_WIDTH-1:0]  cfg_idx_i   = '0;
  logic [rpp_pkg::CFG_DATA_WIDTH-1:0] cfg_data_i  = '0;
  logic                               in_valid_i  = 1'b0;
  logic                               in_ready_o;
  rpp_pkg::coord_t                    point_x_i   = '0;
  rpp_pkg::coord_t                    point_y_i   = '0;
  rpp_pkg::coord_t                    point_z_i   = '0;
  logic                               out_valid_o;
  logic                               out_ready_i = 1'b0;
  rpp_pkg::coord_t                    proj_x_o;
  rpp_pkg::coord_t                    proj_y_o;
  logic                               saturated_o;

  // Expected projections in transfer order, and the register copy they use.
  proj_t                              pending_proj [$];
  longint                             coef_now [NUM_REGS];
  logic [rpp_pkg::CFG_DATA_WIDTH-1:0] cfg_plan [NUM_REGS];

  int   error_count    = 0;
  int   cycle_count    = 0;
  int   rx_hold_cycles = 0;
  logic tx_steady      = 1'b0;
  logic rx_steady      = 1'b0;

  rotate_project_point_3d_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .point_x_i   (point_x_i),
    .point_y_i   (point_y_i),
    .point_z_i   (point_z_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .proj_x_o    (proj_x_o),
    .proj_y_o    (proj_y_o),
    .saturated_o (saturated_o)
  );

  always #5 clk_i = ~clk_i;

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** rotate_project_point_3d_core: FAILED **");
      $finish;
    end
  end

  // Two products summed exactly, rounded to nearest (ties up) and clamped.
  function automatic rpp_pkg::coord_t round_sat(longint a1, longint b1, longint a2,
                                                longint b2, inout logic sat);
    longint          acc;
    rpp_pkg::coord_t res;
    acc = a1 * b1 + a2 * b2 + (longint'(1) <<< (rpp_pkg::COEF_FRAC_BITS - 1));
    acc = acc >>> rpp_pkg::COEF_FRAC_BITS;
    if (acc > COORD_MAX) begin
      sat = 1'b1;
      res = C_MAX;
    end else if (acc < COORD_MIN) begin
      sat = 1'b1;
      res = C_MIN;
    end else begin
      res = rpp_pkg::coord_t'(acc);
    end
    return res;
  endfunction

  // Rotation about Y, then X, then Z, followed by the per-axis scales.
  function automatic proj_t project_point(rpp_pkg::coord_t x, rpp_pkg::coord_t y,
                                          rpp_pkg::coord_t z);
    longint          cx, sx, cy, sy, cz, sz;
    rpp_pkg::coord_t x1, z1, y2, z2, x3, y3;
    logic            sat;
    proj_t           res;
    cx  = coef_now[rpp_pkg::REG_COS_X];
    sx  = coef_now[rpp_pkg::REG_SIN_X];
    cy  = coef_now[rpp_pkg::REG_COS_Y];
    sy  = coef_now[rpp_pkg::REG_SIN_Y];
    cz  = coef_now[rpp_pkg::REG_COS_Z];
    sz  = coef_now[rpp_pkg::REG_SIN_Z];
    sat = 1'b0;
    x1  = round_sat(x, cy, z, sy, sat);
    z1  = round_sat(x, -sy, z, cy, sat);
    y2  = round_sat(y, cx, z1, -sx, sat);
    // The rotated z is not used, but its clamping still raises the flag.
    z2  = round_sat(y, sx, z1, cx, sat);
    x3  = round_sat(x1, cz, y2, -sz, sat);
    y3  = round_sat(x1, sz, y2, cz, sat);
    res.px  = round_sat(x3, coef_now[rpp_pkg::REG_SCALE_X], 0, 0, sat);
    res.py  = round_sat(y3, coef_now[rpp_pkg::REG_SCALE_Y], 0, 0, sat);
    res.sat = sat;
    return res;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    error_count++;
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  // Compare one output transfer with the oldest expected projection.
  task automatic check_result();
    proj_t want;
    if (pending_proj.size() == 0) begin
      report_mismatch("unexpected result proj_x", proj_x_o, 0);
    end else begin
      want = pending_proj.pop_front();
      if (proj_x_o !== want.px) report_mismatch("proj_x", proj_x_o, want.px);
      if (proj_y_o !== want.py) report_mismatch("proj_y", proj_y_o, want.py);
      if (saturated_o !== want.sat) report_mismatch("saturated", saturated_o, want.sat);
    end
  endtask

  // Monitor: predict on every input transfer, check on every output transfer.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        pending_proj.insert(pending_proj.size(),
                            project_point(point_x_i, point_y_i, point_z_i));
      end
      if (out_valid_o && out_ready_i) begin
        check_result();
      end
    end
  end

  // Result side: a random stall before each transfer, or a long hold when asked.
  initial begin : result_sink
    int stall;
    forever begin
      if (rx_hold_cycles > 0) begin
        stall          = rx_hold_cycles;
        rx_hold_cycles = 0;
      end else begin
        stall = rx_steady ? 0 : $urandom_range(0, 6);
      end
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // Offer one point after a random gap and hold it until the transfer.
  task automatic send_point(rpp_pkg::coord_t x, rpp_pkg::coord_t y, rpp_pkg::coord_t z);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    point_x_i  <= x;
    point_y_i  <= y;
    point_z_i  <= z;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Stop offering and let every expected projection come out.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_proj.size() != 0) @(posedge clk_i);
    repeat (rpp_pkg::NUM_STAGES + 2) @(posedge clk_i);
  endtask

  // Sine and cosine registers ignore the upper data bits, so fill them randomly.
  function automatic logic [rpp_pkg::CFG_DATA_WIDTH-1:0] trig_word(int v);
    logic [rpp_pkg::CFG_DATA_WIDTH-1:0] w;
    w                          = rpp_pkg::CFG_DATA_WIDTH'($urandom);
    w[rpp_pkg::TRIG_WIDTH-1:0] = v[rpp_pkg::TRIG_WIDTH-1:0];
    return w;
  endfunction

  task automatic plan_config(int cx, int sx, int cy, int sy, int cz, int sz,
                             int kx, int ky);
    cfg_plan[rpp_pkg::REG_COS_X]   = trig_word(cx);
    cfg_plan[rpp_pkg::REG_SIN_X]   = trig_word(sx);
    cfg_plan[rpp_pkg::REG_COS_Y]   = trig_word(cy);
    cfg_plan[rpp_pkg::REG_SIN_Y]   = trig_word(sy);
    cfg_plan[rpp_pkg::REG_COS_Z]   = trig_word(cz);
    cfg_plan[rpp_pkg::REG_SIN_Z]   = trig_word(sz);
    cfg_plan[rpp_pkg::REG_SCALE_X] = rpp_pkg::CFG_DATA_WIDTH'(kx);
    cfg_plan[rpp_pkg::REG_SCALE_Y] = rpp_pkg::CFG_DATA_WIDTH'(ky);
  endtask

  // Write all registers back to back; the core must be idle.
  task automatic load_config();
    for (int i = 0; i < NUM_REGS; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= rpp_pkg::CFG_IDX_WIDTH'(i);
      cfg_data_i <= cfg_plan[i];
      @(posedge clk_i);
      if (i < rpp_pkg::REG_SCALE_X) begin
        coef_now[i] = longint'(rpp_pkg::trig_t'(cfg_plan[i][rpp_pkg::TRIG_WIDTH-1:0]));
      end else begin
        coef_now[i] = longint'(rpp_pkg::scale_t'(cfg_plan[i]));
      end
    end
    cfg_we_i <= 1'b0;
  endtask

  function automatic int pick_trig(int kind);
    int v;
    case (kind)
      0: v = int'($urandom_range(0, 32768)) - 16384;
      1: begin
        case ($urandom_range(0, 2))
          0:       v = -16384;
          1:       v = 0;
          default: v = 16384;
        endcase
      end
      default: v = int'($urandom);
    endcase
    return v;
  endfunction

  function automatic int pick_scale(int kind);
    int v;
    case (kind)
      0: v = int'($urandom_range(0, 65536)) - 32768;
      1: begin
        case ($urandom_range(0, 3))
          0:       v = -131072;
          1:       v = 131071;
          2:       v = 16384;
          default: v = 0;
        endcase
      end
      default: v = int'($urandom);
    endcase
    return v;
  endfunction

  // Full-range words half of the time, with small, integral and extreme values mixed in.
  function automatic rpp_pkg::coord_t random_coord();
    rpp_pkg::coord_t v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: v = rpp_pkg::coord_t'($urandom);
      5, 6, 7:       v = rpp_pkg::coord_t'(int'($urandom_range(0, 2 ** 21)) - 2 ** 20);
      8: begin
        case ($urandom_range(0, 4))
          0:       v = C_MAX;
          1:       v = C_MIN;
          2:       v = '0;
          3:       v = rpp_pkg::coord_t'(1);
          default: v = rpp_pkg::coord_t'(-1);
        endcase
      end
      default: v = rpp_pkg::coord_t'((int'($urandom_range(0, 512)) - 256) * 65536);
    endcase
    return v;
  endfunction

  // Reset state: identity rotation and unit scales pass points through.
  task automatic test_reset_identity();
    send_point('0, '0, '0);
    send_point(C_MAX, C_MAX, C_MAX);
    send_point(C_MIN, C_MIN, C_MIN);
    send_point(rpp_pkg::coord_t'(1), rpp_pkg::coord_t'(-1), rpp_pkg::coord_t'(12345));
    send_point(rpp_pkg::coord_t'(32'h1234_5678), rpp_pkg::coord_t'(32'hedcb_a987),
               rpp_pkg::coord_t'(32'h5555_aaaa));
    wait_drained();
  endtask

  // Negative unit cosines, unit sines and the widest scales drive every stage to clamp.
  task automatic test_extreme_coefficients();
    plan_config(-16384, 16384, -16384, 16384, -16384, 16384, 131071, -131072);
    load_config();
    send_point(C_MAX, C_MIN, C_MAX);
    send_point(C_MIN, C_MAX, C_MIN);
    send_point(rpp_pkg::coord_t'(32'h0001_0000), rpp_pkg::coord_t'(-32'sh0001_0000),
               rpp_pkg::coord_t'(32'h0000_8000));
    send_point('0, '0, '0);
    wait_drained();
  endtask

  // Coefficients beyond one and sine/cosine pairs that are not normalized.
  task automatic test_unnormalized();
    plan_config(32767, -32768, 20000, 30000, -32768, 32767, 40000, -70000);
    load_config();
    send_point(rpp_pkg::coord_t'(32'h7fff_0000), rpp_pkg::coord_t'(32'h0000_0001),
               rpp_pkg::coord_t'(32'h8000_ffff));
    send_point(rpp_pkg::coord_t'(32'h0000_4000), rpp_pkg::coord_t'(-32'sh0000_4000),
               rpp_pkg::coord_t'(32'h0003_0000));
    send_point(rpp_pkg::coord_t'(7), rpp_pkg::coord_t'(-7), rpp_pkg::coord_t'(3));
    wait_drained();
  endtask

  // Half scales put results exactly on rounding ties in both directions.
  task automatic test_rounding_ties();
    plan_config(16384, 0, 16384, 0, 16384, 0, 8192, -8192);
    load_config();
    send_point(rpp_pkg::coord_t'(1), rpp_pkg::coord_t'(1), '0);
    send_point(rpp_pkg::coord_t'(-1), rpp_pkg::coord_t'(-1), '0);
    send_point(rpp_pkg::coord_t'(3), rpp_pkg::coord_t'(3), '0);
    send_point(rpp_pkg::coord_t'(-3), rpp_pkg::coord_t'(-3), '0);
    wait_drained();
  endtask

  // Random phases, each under a fresh register setting and its own idling mix.
  task automatic test_random_phases();
    int kind;
    for (int p = 0; p < NUM_PHASES; p++) begin
      kind = p % 3;
      plan_config(pick_trig(kind), pick_trig(kind), pick_trig(kind), pick_trig(kind),
                  pick_trig(kind), pick_trig(kind), pick_scale(kind), pick_scale(kind));
      load_config();
      tx_steady = ($urandom_range(0, 2) == 0);
      rx_steady = ($urandom_range(0, 2) == 0);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // Switch idling on and off inside the phase as well.
        if ($urandom_range(0, 19) == 0) tx_steady = ~tx_steady;
        if ($urandom_range(0, 19) == 0) rx_steady = ~rx_steady;
        send_point(random_coord(), random_coord(), random_coord());
      end
      tx_steady = 1'b0;
      rx_steady = 1'b0;
      wait_drained();
    end
  endtask

  // The result side holds off while points keep coming, so the pipeline fills.
  task automatic test_backpressure();
    rx_hold_cycles = 80;
    tx_steady      = 1'b1;
    for (int n = 0; n < 40; n++) begin
      send_point(random_coord(), random_coord(), random_coord());
    end
    tx_steady = 1'b0;
    wait_drained();
  endtask

  initial begin
    coef_now[rpp_pkg::REG_COS_X]   = rpp_pkg::TRIG_ONE;
    coef_now[rpp_pkg::REG_SIN_X]   = rpp_pkg::TRIG_ZERO;
    coef_now[rpp_pkg::REG_COS_Y]   = rpp_pkg::TRIG_ONE;
    coef_now[rpp_pkg::REG_SIN_Y]   = rpp_pkg::TRIG_ZERO;
    coef_now[rpp_pkg::REG_COS_Z]   = rpp_pkg::TRIG_ONE;
    coef_now[rpp_pkg::REG_SIN_Z]   = rpp_pkg::TRIG_ZERO;
    coef_now[rpp_pkg::REG_SCALE_X] = rpp_pkg::SCALE_ONE;
    coef_now[rpp_pkg::REG_SCALE_Y] = rpp_pkg::SCALE_ONE;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_identity();
    test_extreme_coefficients();
    test_unnormalized();
    test_rounding_ties();
    test_backpressure();
    test_random_phases();

    if (pending_proj.size() != 0) begin
      report_mismatch("results left outstanding", 0, pending_proj.size());
    end
    if (error_count == 0) begin
      $display("** rotate_project_point_3d_core: PASSED **");
    end else begin
      $display("** rotate_project_point_3d_core: FAILED **");
    end
    $finish;
  end

endmodule
